// File: sv/vttm_pkg.sv
// ----------------------------------------------------------------------------
// vttm_pkg
// Shared types and constants for the virtual tick timer multiplexer.
// ----------------------------------------------------------------------------
package vttm_pkg;

  localparam int GUEST_COUNT = 4;
  localparam int GIDX_W      = (GUEST_COUNT > 1) ? $clog2(GUEST_COUNT) : 1;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_SWITCH  = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  localparam logic [4:0]  NO_GUEST       = 5'd31;
  localparam logic [24:0] TICK_RELOAD_RST = 25'd16000;
  localparam logic [31:0] U32MAX         = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  guest;
    logic [16:0] hw_csr;
    logic [23:0] hw_rvr;
    logic [23:0] hw_cvr;
    logic        hw_irq_pend;
  } in_req_t;

  typedef struct packed {
    logic        arriving_valid;
    logic [16:0] arm_csr;
    logic [23:0] arm_rvr;
    logic        inject;
    logic [31:0] owed;
    logic [31:0] accrued;
    logic [31:0] injected;
    logic [31:0] coalesced;
    logic [31:0] max_owed;
  } out_req_t;

  // one guest table entry
  typedef struct packed {
    logic [16:0] control;
    logic [23:0] reload;
    logic [23:0] count_now;
    logic [63:0] last_wall;
    logic [31:0] owed;
    logic        pending;
    logic [31:0] accrued;
    logic [31:0] injected;
    logic [31:0] coalesced;
    logic [31:0] max_owed;
  } entry_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [24:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [24:0] rem;
  } div_rsp_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {33'd0, a} + {1'b0, b};
    sat_add = (s > {33'd0, U32MAX}) ? U32MAX : s[31:0];
  endfunction

  function automatic logic irq_on(input logic [16:0] csr);
    irq_on = csr[0] & csr[1];
  endfunction

endpackage

// File: sv/vttm_div.sv
// ----------------------------------------------------------------------------
// vttm_div
// Serial restoring divider, 64 by 25 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vttm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  vttm_pkg::div_req_t req,
  output vttm_pkg::div_rsp_t rsp
);

  logic [63:0] q_r;
  logic [25:0] rem_r;
  logic [24:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [25:0] trial;
  logic [25:0] shifted;

  always_comb begin
    shifted = {rem_r[24:0], q_r[63]};
    trial   = shifted - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done_r <= busy_r && !req.start && (cnt_r == 7'd63);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
        q_r    <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        if (!trial[25]) begin
          rem_r <= trial;
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r   <= {q_r[62:0], 1'b0};
        end
        cnt_r  <= cnt_r + 7'd1;
        busy_r <= (cnt_r != 7'd63);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r[24:0];

endmodule

// File: sv/virtual_tick_timer_multiplexer.sv
// ----------------------------------------------------------------------------
// virtual_tick_timer_multiplexer
// Shares one tick timer among guests; per-guest state lives in a table RAM.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  in      | input     | in_valid, in_stall (out), in_data
//  out     | output    | out_valid, out_stall (in), out_data
//  cfg     | input     | cfg_we, cfg_wdata (tick_reload)
//
// One request at a time. A tick, clear or ignored request passes through S_EMIT
// before the next accept. A switch reads the departing entry, writes it
// back, then reads the arriving entry from the registered table read; the
// serial divider runs when at least one whole tick has elapsed.
// The table has no reset of its own: after reset a clearing pass writes each
// entry while in_stall is held high.
// A result sits in the output register until taken; the next request may be
// accepted meanwhile and waits for the register before it finishes.
module virtual_tick_timer_multiplexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vttm_pkg::in_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vttm_pkg::out_req_t out_data,
  input  logic              cfg_we,
  input  logic [24:0]       cfg_wdata
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DEP_RD, S_DEP_WB, S_ARR_RD, S_ARR_LD, S_ARR_CALC,
    S_DIV, S_ARR_FIN, S_EMIT
  } state_t;

  localparam int GW = vttm_pkg::GIDX_W;

  state_t state_r;
  logic [24:0] tick_reload_r;
  logic [63:0] wall_r;
  logic [4:0]  active_r;
  vttm_pkg::in_req_t req_r;
  vttm_pkg::entry_t  ent_r;
  vttm_pkg::out_req_t res_r;
  logic        res_pend_r;
  logic        out_valid_r;
  vttm_pkg::out_req_t out_data_r;
  logic [GW:0] init_cnt_r;
  logic [24:0] period_r;

  // table RAM
  vttm_pkg::entry_t mem [vttm_pkg::GUEST_COUNT];
  logic           mem_we;
  logic [GW-1:0]  mem_addr;
  vttm_pkg::entry_t mem_wdata;
  vttm_pkg::entry_t mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  vttm_pkg::div_req_t div_req;
  vttm_pkg::div_rsp_t div_rsp;

  vttm_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  logic accept;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic arr_ok, dep_ok;
  assign arr_ok = ({1'b0, req_r.guest} < 5'(vttm_pkg::GUEST_COUNT));
  assign dep_ok = (active_r < 5'(vttm_pkg::GUEST_COUNT));

  // departing save, combinational from the read entry
  vttm_pkg::entry_t dep_e;
  logic hwp;
  always_comb begin
    dep_e = mem_rdata;
    hwp   = req_r.hw_irq_pend;
    if (dep_e.pending && !hwp) begin
      if (dep_e.owed != 32'd0) dep_e.owed = dep_e.owed - 32'd1;
      dep_e.pending = 1'b0;
    end
    dep_e.control   = req_r.hw_csr;
    dep_e.reload    = req_r.hw_rvr;
    dep_e.count_now = req_r.hw_cvr;
    dep_e.last_wall = wall_r;
    if (!dep_e.pending && hwp && vttm_pkg::irq_on(dep_e.control)) begin
      dep_e.owed    = vttm_pkg::sat_add(dep_e.owed, 64'd1);
      dep_e.pending = 1'b1;
      dep_e.accrued = vttm_pkg::sat_add(dep_e.accrued, 64'd1);
      if (dep_e.owed > dep_e.max_owed) dep_e.max_owed = dep_e.owed;
    end
  end

  // arriving first-stage values
  logic [24:0] a_period, a_remaining;
  logic [63:0] a_elapsed;
  logic [24:0] a_cvr;
  logic        calc_upd, calc_div;
  always_comb begin
    a_period  = {1'b0, ent_r.reload} + 25'd1;
    a_cvr     = {1'b0, ent_r.count_now};
    a_remaining = (a_cvr == 25'd0 || a_cvr >= a_period) ? a_period : a_cvr + 25'd1;
    a_elapsed = wall_r - ent_r.last_wall;
    // accounted before, enabled and time moved on
    calc_upd  = ent_r.last_wall != 64'd0 && ent_r.control[0] && a_elapsed != 64'd0;
    // at least one whole tick elapsed
    calc_div  = calc_upd && a_elapsed >= {39'd0, a_remaining};
  end

  logic [24:0] rem_left;
  assign rem_left = period_r - div_rsp.rem - 25'd1;

  // finish: inject logic and result build
  vttm_pkg::entry_t fin_e;
  vttm_pkg::out_req_t fin_o;
  always_comb begin
    fin_e = ent_r;
    fin_o = '0;
    fin_o.arriving_valid = 1'b1;
    fin_o.arm_csr = ent_r.control[0] ? {1'b0, ent_r.control[15:0]} : 17'd0;
    fin_o.arm_rvr = ent_r.reload;
    if (ent_r.owed != 32'd0 && vttm_pkg::irq_on(ent_r.control)) begin
      if (!ent_r.pending) begin
        fin_e.pending  = 1'b1;
        fin_e.injected = vttm_pkg::sat_add(ent_r.injected, 64'd1);
      end else begin
        fin_e.coalesced = vttm_pkg::sat_add(ent_r.coalesced, 64'd1);
      end
      fin_o.inject = 1'b1;
    end
    fin_o.owed      = fin_e.owed;
    fin_o.accrued   = fin_e.accrued;
    fin_o.injected  = fin_e.injected;
    fin_o.coalesced = fin_e.coalesced;
    fin_o.max_owed  = fin_e.max_owed;
  end

  vttm_pkg::entry_t clr_e;
  always_comb begin
    clr_e = '0;
    clr_e.last_wall = wall_r;
  end

  // table port and divider request control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = req_r.guest[GW-1:0];
    mem_wdata = clr_e;
    div_req   = '0;
    div_req.divisor = period_r;
    case (state_r)
      S_INIT: begin
        mem_we   = 1'b1;
        mem_addr = init_cnt_r[GW-1:0];
      end
      S_IDLE: begin
        if (accept && in_data.cmd == vttm_pkg::CMD_CLEAR &&
            {1'b0, in_data.guest} < 5'(vttm_pkg::GUEST_COUNT)) begin
          mem_we   = 1'b1;
          mem_addr = in_data.guest[GW-1:0];
        end else if (accept && in_data.cmd == vttm_pkg::CMD_SWITCH) begin
          mem_addr = active_r[GW-1:0];
        end
      end
      S_DEP_RD: mem_addr = active_r[GW-1:0];
      S_DEP_WB: begin
        mem_we    = dep_ok;
        mem_addr  = active_r[GW-1:0];
        mem_wdata = dep_e;
      end
      S_ARR_FIN: begin
        mem_we    = !res_pend_r;
        mem_wdata = fin_e;
      end
      default: ;
    endcase
    if (state_r == S_ARR_CALC && calc_div) begin
      div_req.start    = 1'b1;
      div_req.dividend = a_elapsed - {39'd0, a_remaining};
      div_req.divisor  = a_period;
    end
  end

  logic [63:0] ticks;
  assign ticks = div_rsp.quot + 64'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      tick_reload_r <= vttm_pkg::TICK_RELOAD_RST;
      wall_r        <= '0;
      active_r      <= vttm_pkg::NO_GUEST;
      out_valid_r   <= 1'b0;
      res_pend_r    <= 1'b0;
      init_cnt_r    <= '0;
    end else begin
      if (cfg_we) tick_reload_r <= cfg_wdata;
      // pending result moves into the output register when free
      if (res_pend_r && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
        res_pend_r  <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          init_cnt_r <= init_cnt_r + {{GW{1'b0}}, 1'b1};
          if (init_cnt_r == (GW+1)'(vttm_pkg::GUEST_COUNT - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            req_r <= in_data;
            case (in_data.cmd)
              vttm_pkg::CMD_TICK: begin
                wall_r <= wall_r + {39'd0, tick_reload_r};
                state_r <= S_EMIT;
              end
              vttm_pkg::CMD_SWITCH: state_r <= S_DEP_RD;
              default: state_r <= S_EMIT;
            endcase
          end
        end
        S_DEP_RD: state_r <= S_DEP_WB;
        S_DEP_WB: begin
          active_r <= {1'b0, req_r.guest};
          if (arr_ok) state_r <= S_ARR_RD;
          else state_r <= S_EMIT;
        end
        S_ARR_RD: state_r <= S_ARR_LD;
        // arriving entry valid in the cycle after its read
        S_ARR_LD: begin
          ent_r   <= mem_rdata;
          state_r <= S_ARR_CALC;
        end
        S_ARR_CALC: begin
          ent_r.last_wall <= wall_r;
          period_r <= a_period;
          if (calc_div) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_ARR_FIN;
            if (calc_upd) begin
              ent_r.count_now <= 24'(a_remaining - a_elapsed[24:0] - 25'd1);
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            ent_r.count_now <= rem_left[23:0];
            ent_r.owed      <= vttm_pkg::sat_add(ent_r.owed, ticks);
            ent_r.accrued   <= vttm_pkg::sat_add(ent_r.accrued, ticks);
            ent_r.max_owed  <= (vttm_pkg::sat_add(ent_r.owed, ticks) > ent_r.max_owed) ?
                               vttm_pkg::sat_add(ent_r.owed, ticks) : ent_r.max_owed;
            state_r <= S_ARR_FIN;
          end
        end
        S_ARR_FIN: begin
          if (!res_pend_r) begin
            res_r      <= fin_o;
            res_pend_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!res_pend_r) begin
            res_r      <= '0;
            res_pend_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/tb_virtual_tick_timer_multiplexer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_virtual_tick_timer_multiplexer
// Self-checking bench: drives tick, switch, clear and ignored requests with random
// gaps and output stalls, predicts every result from a behavioral copy of the
// guest table and compares each field of each accepted result in order.
// ----------------------------------------------------------------------------
module tb_virtual_tick_timer_multiplexer;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request moving
  localparam int SETTLE_CYCLES  = 80;    // margin covering a switch with a division
  localparam int RANDOM_ITEMS   = 1660;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  vttm_pkg::in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  vttm_pkg::out_req_t out_data;
  logic     cfg_we;
  logic [24:0] cfg_wdata;

  virtual_tick_timer_multiplexer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // --------------------------------------------------------------------------
  // Behavioral copy of the block state
  // --------------------------------------------------------------------------
  logic [24:0] slice_len;
  logic [63:0] wall_now;
  logic [4:0]  cur_guest;
  vttm_pkg::entry_t gtab [vttm_pkg::GUEST_COUNT];

  vttm_pkg::out_req_t pending_results[$];
  int       errors;
  logic     quiet;      // no gaps, no stalls
  int       n_tick, n_switch, n_clear, n_other, n_results, n_inject;

  function automatic logic [31:0] sat32(input logic [31:0] a, input logic [63:0] b);
    sat32 = (b > {32'd0, 32'hFFFF_FFFF - a}) ? 32'hFFFF_FFFF : a + b[31:0];
  endfunction

  function automatic void wipe_guest(input int g);
    gtab[g] = '0;
    gtab[g].last_wall = wall_now;
  endfunction

  // Store the timer snapshot of the guest that is leaving.
  function automatic void save_leaving(input vttm_pkg::in_req_t r);
    int g;
    g = cur_guest;
    if (g >= vttm_pkg::GUEST_COUNT) return;
    // a tick that was pending and has been taken since is settled
    if (gtab[g].pending && !r.hw_irq_pend) begin
      if (gtab[g].owed != 0) gtab[g].owed = gtab[g].owed - 1;
      gtab[g].pending = 1'b0;
    end
    gtab[g].control   = r.hw_csr;
    gtab[g].reload    = r.hw_rvr;
    gtab[g].count_now = r.hw_cvr;
    gtab[g].last_wall = wall_now;
    if (!gtab[g].pending && r.hw_irq_pend && gtab[g].control[0] && gtab[g].control[1]) begin
      gtab[g].owed     = sat32(gtab[g].owed, 64'd1);
      gtab[g].pending  = 1'b1;
      gtab[g].accrued  = sat32(gtab[g].accrued, 64'd1);
      if (gtab[g].owed > gtab[g].max_owed) gtab[g].max_owed = gtab[g].owed;
    end
  endfunction

  // Turn wall time elapsed since last accounting into owed ticks.
  function automatic void catch_up(input int g);
    logic [63:0] span, ticks, rest;
    logic [31:0] period, left, cv;
    if (gtab[g].last_wall == 64'd0) begin
      gtab[g].last_wall = wall_now;  // first accounting only records wall time
      return;
    end
    span = wall_now - gtab[g].last_wall;
    gtab[g].last_wall = wall_now;
    if (!gtab[g].control[0] || span == 64'd0) return;
    period = {8'd0, gtab[g].reload} + 32'd1;
    cv     = {8'd0, gtab[g].count_now};
    // a zero or out-of-range count leaves a full period
    left   = (cv == 0 || cv >= period) ? period : cv + 32'd1;
    if (span < {32'd0, left}) begin
      gtab[g].count_now = 24'(left - span[31:0] - 32'd1);
      return;
    end
    span  = span - {32'd0, left};
    ticks = 64'd1 + span / {32'd0, period};
    rest  = span % {32'd0, period};
    gtab[g].count_now = 24'(period - rest[31:0] - 32'd1);
    gtab[g].owed      = sat32(gtab[g].owed, ticks);
    gtab[g].accrued   = sat32(gtab[g].accrued, ticks);
    if (gtab[g].owed > gtab[g].max_owed) gtab[g].max_owed = gtab[g].owed;
  endfunction

  function automatic vttm_pkg::out_req_t timer_mux_result(input vttm_pkg::in_req_t r);
    vttm_pkg::out_req_t o;
    int g;
    o = '0;
    case (r.cmd)
      vttm_pkg::CMD_TICK:  wall_now = wall_now + {39'd0, slice_len};
      vttm_pkg::CMD_CLEAR: if (r.guest < vttm_pkg::GUEST_COUNT) wipe_guest(r.guest);
      vttm_pkg::CMD_SWITCH: begin
        save_leaving(r);
        cur_guest = {1'b0, r.guest};
        if (r.guest < vttm_pkg::GUEST_COUNT) begin
          g = r.guest;
          catch_up(g);
          o.arriving_valid = 1'b1;
          o.arm_csr = gtab[g].control[0] ? (gtab[g].control & 17'h0FFFF) : 17'd0;
          o.arm_rvr = gtab[g].reload;
          if (gtab[g].owed != 0 && gtab[g].control[0] && gtab[g].control[1]) begin
            if (!gtab[g].pending) begin
              gtab[g].pending  = 1'b1;
              gtab[g].injected = sat32(gtab[g].injected, 64'd1);
            end else begin
              gtab[g].coalesced = sat32(gtab[g].coalesced, 64'd1);
            end
            o.inject = 1'b1;
          end
          o.owed      = gtab[g].owed;
          o.accrued   = gtab[g].accrued;
          o.injected  = gtab[g].injected;
          o.coalesced = gtab[g].coalesced;
          o.max_owed  = gtab[g].max_owed;
        end
      end
      default: ;  // command three changes nothing
    endcase
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: holds valid and payload until accepted, then maybe a gap
  // --------------------------------------------------------------------------
  task automatic send_request(input vttm_pkg::in_req_t r);
    int gap;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(timer_mux_result(r));
    case (r.cmd)
      vttm_pkg::CMD_TICK:   n_tick++;
      vttm_pkg::CMD_SWITCH: n_switch++;
      vttm_pkg::CMD_CLEAR:  n_clear++;
      default:              n_other++;
    endcase
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic make_req(input logic [1:0] c, input logic [3:0] g, input logic [16:0] csr,
                          input logic [23:0] rvr, input logic [23:0] cvr, input logic hp);
    vttm_pkg::in_req_t r;
    r.cmd = c; r.guest = g; r.hw_csr = csr; r.hw_rvr = rvr; r.hw_cvr = cvr; r.hw_irq_pend = hp;
    send_request(r);
  endtask

  // Block idle: all results in, plus a margin for work still in flight.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slice(input logic [24:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    slice_len = v;
  endtask

  // --------------------------------------------------------------------------
  // Result checker and output stall generator
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: mismatch %s expected 0x%0h actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    vttm_pkg::out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result 0x%0h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        if (want.inject) n_inject++;
        check_field("arriving_valid", want.arriving_valid, out_data.arriving_valid);
        check_field("arm_csr", want.arm_csr, out_data.arm_csr);
        check_field("arm_rvr", want.arm_rvr, out_data.arm_rvr);
        check_field("inject", want.inject, out_data.inject);
        check_field("owed", want.owed, out_data.owed);
        check_field("accrued", want.accrued, out_data.accrued);
        check_field("injected", want.injected, out_data.injected);
        check_field("coalesced", want.coalesced, out_data.coalesced);
        check_field("max_owed", want.max_owed, out_data.max_owed);
      end
    end
  end

  int stall_hold;
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_hold <= $urandom_range(0, 5);
    end
  end

  // Watchdog: no request moving on either channel for too long
  int idle_cycles;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases at the reset slice length.
  task automatic test_directed;
    make_req(vttm_pkg::CMD_SWITCH, 4'd1, 17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    // nobody leaving, first accounting
    make_req(vttm_pkg::CMD_TICK,   4'd0, 17'd0, 24'd0, 24'd0, 1'b0);
    make_req(vttm_pkg::CMD_TICK,   4'd15, 17'd0, 24'd0, 24'd0, 1'b0);
    // guest 1 leaves with a pending tick
    make_req(vttm_pkg::CMD_SWITCH, 4'd2, 17'h10007, 24'd99, 24'd0, 1'b1);
    make_req(vttm_pkg::CMD_TICK,   4'd0, 17'd0, 24'd0, 24'd0, 1'b0);
    make_req(vttm_pkg::CMD_TICK,   4'd0, 17'd0, 24'd0, 24'd0, 1'b0);
    // back to 1: many periods elapsed, tick merges into the pending one
    make_req(vttm_pkg::CMD_SWITCH, 4'd1, 17'h00003, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    // leaving 1 with the interrupt taken; count beyond the period
    make_req(vttm_pkg::CMD_SWITCH, 4'd2, 17'h00003, 24'd50, 24'd200, 1'b0);
    make_req(vttm_pkg::CMD_TICK,   4'd0, 17'd0, 24'd0, 24'd0, 1'b0);
    make_req(vttm_pkg::CMD_SWITCH, 4'd1, 17'h00001, 24'd40000, 24'd7, 1'b1);
    make_req(vttm_pkg::CMD_TICK,   4'd0, 17'd0, 24'd0, 24'd0, 1'b0);
    make_req(vttm_pkg::CMD_SWITCH, 4'd2, 17'h10005, 24'd40000, 24'd39999, 1'b0);
    // nobody arriving
    make_req(vttm_pkg::CMD_SWITCH, 4'd9, 17'h00003, 24'd10, 24'd3, 1'b1);
    make_req(vttm_pkg::CMD_CLEAR,  4'd1, 17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    // clear of nobody
    make_req(vttm_pkg::CMD_CLEAR,  4'd12, 17'd0, 24'd0, 24'd0, 1'b0);
    // ignored
    make_req(vttm_pkg::CMD_IGNORED, 4'd2, 17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    make_req(vttm_pkg::CMD_SWITCH, 4'd3, 17'd0, 24'd0, 24'd0, 1'b0);
    // 3 saved disabled
    make_req(vttm_pkg::CMD_SWITCH, 4'd0, 17'd0, 24'd0, 24'd0, 1'b1);
    make_req(vttm_pkg::CMD_TICK,   4'd0, 17'd0, 24'd0, 24'd0, 1'b0);
    make_req(vttm_pkg::CMD_SWITCH, 4'd3, 17'h00003, 24'd0, 24'd0, 1'b1);
    // no time elapsed
    make_req(vttm_pkg::CMD_SWITCH, 4'd3, 17'h00003, 24'd5, 24'd2, 1'b1);
    make_req(vttm_pkg::CMD_SWITCH, 4'd1, 17'h00007, 24'd1, 24'd1, 1'b0);
  endtask

  // Counter saturation: reload of zero and wall time advanced past 2^32.
  task automatic test_saturation;
    write_slice(25'h1000000);
    make_req(vttm_pkg::CMD_TICK,   4'd0, 17'd0, 24'd0, 24'd0, 1'b0);
    make_req(vttm_pkg::CMD_CLEAR,  4'd0, 17'd0, 24'd0, 24'd0, 1'b0);
    make_req(vttm_pkg::CMD_SWITCH, 4'd0, 17'd0, 24'd0, 24'd0, 1'b0);
    make_req(vttm_pkg::CMD_SWITCH, 4'd15, 17'h00003, 24'd0, 24'd0, 1'b0);
    repeat (260) make_req(vttm_pkg::CMD_TICK, 4'd0, 17'd0, 24'd0, 24'd0, 1'b0);
    make_req(vttm_pkg::CMD_SWITCH, 4'd0, 17'd0, 24'd0, 24'd0, 1'b0);
    // +1 stays at max
    make_req(vttm_pkg::CMD_SWITCH, 4'd0, 17'h00003, 24'd0, 24'd0, 1'b1);
    // settle, owed decrements
    make_req(vttm_pkg::CMD_SWITCH, 4'd0, 17'h00003, 24'd0, 24'd0, 1'b0);
  endtask

  // Random request mix; mostly ticks and switches among real guests.
  task automatic test_random(input int count);
    vttm_pkg::in_req_t r;
    int pick;
    int span;
    span = (slice_len > 25'd4000000) ? 24'hFFFFFF : int'(slice_len) * 4 + 3;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      r.cmd = (pick < 42) ? vttm_pkg::CMD_TICK :
              (pick < 90) ? vttm_pkg::CMD_SWITCH :
              (pick < 97) ? vttm_pkg::CMD_CLEAR : vttm_pkg::CMD_IGNORED;
      r.guest = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, vttm_pkg::GUEST_COUNT - 1))
                                            : 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) != 0)
        r.hw_csr = {1'($urandom_range(0, 1)), 13'd0, 3'($urandom_range(0, 7))};
      else
        r.hw_csr = 17'($urandom_range(0, 17'h1FFFF));
      r.hw_rvr = ($urandom_range(0, 4) != 0) ? 24'($urandom_range(0, span))
                                             : 24'($urandom_range(0, 24'hFFFFFF));
      r.hw_cvr = ($urandom_range(0, 4) != 0) ? 24'($urandom_range(0, r.hw_rvr + 2))
                                             : 24'($urandom_range(0, 24'hFFFFFF));
      r.hw_irq_pend = 1'($urandom_range(0, 1));
      send_request(r);
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    stall_hold = 0;
    idle_cycles = 0;
    errors = 0; quiet = 1'b0;
    n_tick = 0; n_switch = 0; n_clear = 0; n_other = 0; n_results = 0; n_inject = 0;
    slice_len = vttm_pkg::TICK_RELOAD_RST;
    wall_now  = '0;
    cur_guest = vttm_pkg::NO_GUEST;
    for (int g = 0; g < vttm_pkg::GUEST_COUNT; g++) gtab[g] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_saturation();
    write_slice(25'd1);
    test_random(RANDOM_ITEMS / 5);
    write_slice(25'd777);
    test_random(RANDOM_ITEMS / 5);
    write_slice(25'h1000000);
    test_random(RANDOM_ITEMS / 5);
    write_slice(25'($urandom_range(1, 200000)));
    test_random(RANDOM_ITEMS / 5);
    write_slice(25'd16000);
    quiet = 1'b1;  // last stretch back to back
    test_random(RANDOM_ITEMS / 5);
    drain();

    $display("Covered %0d ticks, %0d switches, %0d clears, %0d ignored requests;",
             n_tick, n_switch, n_clear, n_other);
    $display("%0d results checked, %0d with a tick injected.", n_results, n_inject);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
